>>> hw/rtl/upd_pkg.sv
// Shared types and constants for the URL percent decoder.
// Holds the channel payload structs, the job record that the parser hands
// to the output serializer, and the job queue sizing.
`timescale 1ns / 1ps

package upd_pkg;

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_text_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_run_last;
        logic       out_text_end;
    } out_item_t;

    // One input byte's worth of output: up to three bytes, emitted in order.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      cnt;
        logic            text_end;
    } job_t;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    // 'A' - 10: offset that turns a hex value 10..15 into an uppercase letter
    localparam logic [7:0] HEX_UOFS = 8'h37;

endpackage

>>> hw/rtl/url_percent_decoder.sv
// Top level of the URL percent decoder: parser, job queue and serializer.
// Depends on upd_pkg, upd_front, upd_queue and upd_back.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------------
//   src     | in        | src_valid/src_stall  | in_char, in_text_end
//   dst     | out       | dst_valid/dst_stall  | out_char, out_run_last, out_text_end
//
// The parser takes one byte per cycle while the four-entry job queue has room;
// each byte becomes zero to three output bytes.
// The serializer emits one output byte per cycle while dst_stall is low, from the
// head job into a registered output; a result passes through a queue slot and
// the output register. Output rate, one byte per cycle, sets the sustained rate.
// Reset clears the parse phase, queue pointers and output valid at once.
// dst_stall holds the output register; src_stall rises only when the queue fills.
`timescale 1ns / 1ps

module url_percent_decoder
    import upd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    output logic      src_stall,
    input  in_item_t  src_item,
    output logic      dst_valid,
    input  logic      dst_stall,
    output out_item_t dst_item
);

    logic push;
    job_t push_job;
    logic pop;
    job_t head;
    logic empty;
    logic full;

    upd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .q_full    (full),
        .push      (push),
        .push_job  (push_job)
    );

    upd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    upd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .head      (head),
        .pop       (pop),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_item  (dst_item)
    );

endmodule

>>> hw/rtl/upd_front.sv
// Escape parser: accepts input transactions, tracks the escape phase and
// held digit, and builds one job of zero to three output bytes per byte.
// Depends on upd_pkg.
`timescale 1ns / 1ps

module upd_front
    import upd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     src_valid,
    output logic     src_stall,
    input  in_item_t src_item,
    input  logic     q_full,
    output logic     push,
    output job_t     push_job
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_PCT  = 2'd1;
    localparam logic [1:0] PH_DIG  = 2'd2;

    logic [1:0] phase_reg, phase_next;
    logic [3:0] held_reg, held_next;
    logic       accept;
    logic [7:0] ch;
    logic       ch_dec;
    logic       ch_upper;
    logic       ch_lower;
    logic [3:0] hex_v;
    logic [7:0] code;
    logic       code_in_set;
    logic [7:0] hex_echo;
    logic [7:0] held_char;
    job_t       job;

    assign ch       = src_item.in_char;
    assign ch_dec   = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign ch_upper = (ch >= CH_UA) && (ch <= CH_UF);
    assign ch_lower = (ch >= CH_LA) && (ch <= CH_LF);
    // Letters A-F and a-f both carry value low nibble + 9.
    assign hex_v    = ch_dec ? ch[3:0] : (ch[3:0] + 4'd9);
    assign code     = {held_reg, hex_v};
    assign code_in_set = ((code >= 8'h20) && (code <= 8'h2F))
                      || ((code >= 8'h3A) && (code <= 8'h40))
                      || ((code >= 8'h5B) && (code <= 8'h60))
                      || ((code >= 8'h7B) && (code <= 8'h7E));
    assign hex_echo       = (hex_v < 4'd10) ? (CH_ZERO + {4'b0, hex_v})
                                            : (HEX_UOFS + {4'b0, hex_v});
    assign held_char      = CH_ZERO + {4'b0, held_reg};

    always_comb
    begin
        phase_next    = phase_reg;
        held_next     = held_reg;
        job.bytes     = '0;
        job.cnt       = 2'd0;
        job.text_end  = src_item.in_text_end;
        unique case (phase_reg)
            PH_PCT:
            begin
                if (ch_dec)
                begin
                    held_next  = ch[3:0];
                    phase_next = PH_DIG;
                end
                else
                begin
                    job.bytes[0] = CH_PCT;
                    job.bytes[1] = ch;
                    job.cnt      = 2'd2;
                    phase_next   = PH_IDLE;
                    held_next    = 4'd0;
                end
            end
            PH_DIG:
            begin
                if ((ch_dec || ch_upper || ch_lower) && code_in_set)
                begin
                    job.bytes[0] = code;
                    job.cnt      = 2'd1;
                end
                else
                begin
                    job.bytes[0] = CH_PCT;
                    job.bytes[1] = held_char;
                    job.bytes[2] = (ch_dec || ch_upper || ch_lower) ? hex_echo : ch;
                    job.cnt      = 2'd3;
                end
                phase_next = PH_IDLE;
                held_next  = 4'd0;
            end
            default:
            begin
                // Idle, and the unused phase code behaves the same.
                if (ch == CH_PCT)
                begin
                    phase_next = PH_PCT;
                    held_next  = 4'd0;
                end
                else
                begin
                    job.bytes[0] = ch;
                    job.cnt      = 2'd1;
                end
                if (phase_reg != PH_IDLE)
                begin
                    phase_next = (ch == CH_PCT) ? PH_PCT : PH_IDLE;
                end
            end
        endcase

        // Flush a pending escape at end of string; the job is empty here.
        if (src_item.in_text_end)
        begin
            if (phase_next == PH_PCT)
            begin
                job.bytes[0] = CH_PCT;
                job.cnt      = 2'd1;
            end
            else if (phase_next == PH_DIG)
            begin
                job.bytes[0] = CH_PCT;
                job.bytes[1] = CH_ZERO + {4'b0, held_next};
                job.cnt      = 2'd2;
            end
            phase_next = PH_IDLE;
            held_next  = 4'd0;
        end
    end

    assign src_stall = q_full;
    assign accept    = src_valid && !q_full;
    assign push      = accept && (job.cnt != 2'd0);
    assign push_job  = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= 4'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

>>> hw/rtl/upd_queue.sv
// Short job queue between the parser and the output serializer.
// Depends on upd_pkg for the job record and the depth.
`timescale 1ns / 1ps

module upd_queue
    import upd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic empty,
    output logic full
);

    job_t              slots_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == QCNT_W'(QDEPTH));
    assign head  = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

>>> hw/rtl/upd_back.sv
// Output serializer: walks the head job's bytes one per cycle while not
// stalled into a registered output, retiring the job after its last byte.
// Depends on upd_pkg.
`timescale 1ns / 1ps

module upd_back
    import upd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      empty,
    input  job_t      head,
    output logic      pop,
    output logic      dst_valid,
    input  logic      dst_stall,
    output out_item_t dst_item
);

    logic [1:0] sel_reg;
    logic       dst_valid_reg;
    out_item_t  dst_item_reg;
    logic       load;
    logic       is_last;
    logic [7:0] cur_byte;

    assign load    = !dst_valid_reg || !dst_stall;
    assign is_last = (sel_reg == (head.cnt - 2'd1));
    assign pop     = load && !empty && is_last;

    always_comb
    begin
        unique case (sel_reg)
            2'd0:    cur_byte = head.bytes[0];
            2'd1:    cur_byte = head.bytes[1];
            default: cur_byte = head.bytes[2];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg       <= 2'd0;
            dst_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            dst_valid_reg <= !empty;
            if (!empty)
            begin
                sel_reg <= is_last ? 2'd0 : (sel_reg + 2'd1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !empty)
        begin
            dst_item_reg.out_char     <= cur_byte;
            dst_item_reg.out_run_last <= is_last;
            dst_item_reg.out_text_end <= is_last && head.text_end;
        end
    end

    assign dst_valid = dst_valid_reg;
    assign dst_item  = dst_item_reg;

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for url_percent_decoder: random and directed byte streams.
// Predicts decoded bytes in-line and checks each output transaction in order.
// Depends on upd_pkg and the url_percent_decoder RTL.
`timescale 1ns / 1ps

module tb_top;
    import upd_pkg::*;

    localparam int TOTAL_BYTES = 470;
    localparam int QUIET_TAIL  = 60;
    localparam int HANG_LIMIT  = 2000;

    typedef enum logic [1:0] {SCAN_IDLE, SCAN_PCT, SCAN_DIGIT} scan_t;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      src_valid = 1'b0;
    logic      src_stall;
    in_item_t  src_item  = '0;
    logic      dst_valid;
    logic      dst_stall = 1'b0;
    out_item_t dst_item;

    in_item_t  pending_q[$];
    out_item_t decoded_q[$];

    scan_t      scan_phase = SCAN_IDLE;
    logic [3:0] held_digit = '0;

    bit failed      = 1'b0;
    int src_gap     = 0;
    int stall_left  = 0;
    bit src_bursty  = 1'b1;
    bit dst_bursty  = 1'b1;
    int hang_cycles = 0;

    url_percent_decoder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_item  (dst_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic add_byte(input logic [7:0] c, input bit last);
        in_item_t it;
        it.in_char     = c;
        it.in_text_end = last;
        pending_q.push_back(it);
    endtask

    task automatic add_text(input string s, input bit end_on_last);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i], end_on_last && (i == s.len() - 1));
    endtask

    // Work out the decoded bytes for one input byte and queue them.
    task automatic decode_byte(input in_item_t it);
        logic [7:0] seq[$];
        logic [7:0] c;
        logic [7:0] code;
        int         nib;
        out_item_t  o;
        c   = it.in_char;
        nib = -1;
        if (c >= CH_ZERO && c <= CH_NINE)
            nib = c - CH_ZERO;
        else if (c >= CH_UA && c <= CH_UF)
            nib = c - CH_UA + 10;
        else if (c >= CH_LA && c <= CH_LF)
            nib = c - CH_LA + 10;
        case (scan_phase)
            SCAN_PCT:
            begin
                if (c >= CH_ZERO && c <= CH_NINE)
                begin
                    held_digit = 4'(c - CH_ZERO);
                    scan_phase = SCAN_DIGIT;
                end
                else
                begin
                    seq.push_back(CH_PCT);
                    seq.push_back(c);
                    scan_phase = SCAN_IDLE;
                    held_digit = '0;
                end
            end
            SCAN_DIGIT:
            begin
                code = {held_digit, 4'(nib)};
                // Decode only the punctuation ranges; echo anything else.
                if (nib >= 0 && ((code >= 8'h20 && code <= 8'h2F) ||
                                 (code >= 8'h3A && code <= 8'h40) ||
                                 (code >= 8'h5B && code <= 8'h60) ||
                                 (code >= 8'h7B && code <= 8'h7E)))
                    seq.push_back(code);
                else
                begin
                    seq.push_back(CH_PCT);
                    seq.push_back(8'(CH_ZERO + held_digit));
                    if (nib < 0)
                        seq.push_back(c);
                    else if (nib < 10)
                        seq.push_back(8'(CH_ZERO + nib));
                    else
                        seq.push_back(8'(HEX_UOFS + nib));
                end
                scan_phase = SCAN_IDLE;
                held_digit = '0;
            end
            default:
            begin
                if (c == CH_PCT)
                begin
                    scan_phase = SCAN_PCT;
                    held_digit = '0;
                end
                else
                    seq.push_back(c);
            end
        endcase
        // Flush a pending escape at end of string.
        if (it.in_text_end)
        begin
            if (scan_phase == SCAN_PCT)
                seq.push_back(CH_PCT);
            else if (scan_phase == SCAN_DIGIT)
            begin
                seq.push_back(CH_PCT);
                seq.push_back(8'(CH_ZERO + held_digit));
            end
            scan_phase = SCAN_IDLE;
            held_digit = '0;
        end
        for (int k = 0; k < seq.size(); k++)
        begin
            o.out_char     = seq[k];
            o.out_run_last = (k == seq.size() - 1);
            o.out_text_end = (k == seq.size() - 1) && it.in_text_end;
            decoded_q.push_back(o);
        end
    endtask

    // Driver: hold a stalled transaction, otherwise idle in bursts or send the next byte.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (src_valid && !src_stall)
            begin
                decode_byte(src_item);
                if ($urandom_range(0, 29) == 0)
                    src_bursty = !src_bursty;
            end
            if (!src_valid || !src_stall)
            begin
                if (src_gap > 0)
                begin
                    src_gap   = src_gap - 1;
                    src_valid <= 1'b0;
                end
                else if (pending_q.size() == 0)
                    src_valid <= 1'b0;
                else if (pending_q.size() > QUIET_TAIL && src_bursty &&
                         $urandom_range(0, 5) == 0)
                begin
                    src_gap   = $urandom_range(1, 9) - 1;
                    src_valid <= 1'b0;
                end
                else
                begin
                    src_valid <= 1'b1;
                    src_item  <= pending_q.pop_front();
                end
            end
        end
    end

    // Monitor: check each output transaction, then decide the stall for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (dst_valid && !dst_stall)
            begin
                if (decoded_q.size() == 0)
                begin
                    $error("unexpected output: out_char %h", dst_item.out_char);
                    failed = 1'b1;
                end
                else
                begin
                    out_item_t want;
                    want = decoded_q.pop_front();
                    if (dst_item.out_char !== want.out_char)
                    begin
                        $error("out_char: expected %h, got %h",
                               want.out_char, dst_item.out_char);
                        failed = 1'b1;
                    end
                    if (dst_item.out_run_last !== want.out_run_last)
                    begin
                        $error("out_run_last: expected %b, got %b",
                               want.out_run_last, dst_item.out_run_last);
                        failed = 1'b1;
                    end
                    if (dst_item.out_text_end !== want.out_text_end)
                    begin
                        $error("out_text_end: expected %b, got %b",
                               want.out_text_end, dst_item.out_text_end);
                        failed = 1'b1;
                    end
                end
                if ($urandom_range(0, 29) == 0)
                    dst_bursty = !dst_bursty;
            end
            if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                dst_stall  <= 1'b1;
            end
            else if (pending_q.size() > QUIET_TAIL && dst_bursty && !dst_stall &&
                     $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 9) - 1;
                dst_stall  <= 1'b1;
            end
            else
                dst_stall <= 1'b0;
        end
    end

    // Watchdog: end the run when no transaction moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((src_valid && !src_stall) || (dst_valid && !dst_stall))
                hang_cycles = 0;
            else
                hang_cycles = hang_cycles + 1;
            if (hang_cycles >= HANG_LIMIT)
            begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        int         len;
        int         kind;
        int         d;
        int         v;
        bit         fin;
        logic [7:0] dig;
        logic [7:0] hx;

        // Directed: field extremes, decodes, unknown codes, broken escapes, flushes.
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b1);
        add_text("%20", 1'b0);
        add_text("%7e", 1'b0);
        add_text("%7f", 1'b0);
        add_text("%%", 1'b0);
        add_byte(CH_PCT, 1'b0);
        add_byte(8'h00, 1'b0);
        add_text("%3", 1'b0);
        add_byte(8'hFF, 1'b0);
        add_text("%", 1'b1);
        add_text("%9", 1'b1);
        add_text("%3A", 1'b1);

        // Random strings: well-formed escapes, plain bytes, and escapes broken or cut short.
        while (pending_q.size() < TOTAL_BYTES)
        begin
            len = $urandom_range(1, 12);
            for (int e = 0; e < len; e++)
            begin
                fin  = (e == len - 1);
                kind = $urandom_range(0, 9);
                if ($urandom_range(0, 9) < 7)
                begin
                    case ($urandom_range(0, 3))
                        0:       d = 2;
                        1:       d = 3;
                        2:       d = 5;
                        default: d = 7;
                    endcase
                end
                else
                    d = $urandom_range(0, 9);
                dig = 8'(CH_ZERO + d);
                v   = $urandom_range(0, 15);
                if (v < 10)
                    hx = 8'(CH_ZERO + v);
                else if ($urandom_range(0, 1) == 1)
                    hx = 8'(CH_LA + v - 10);
                else
                    hx = 8'(CH_UA + v - 10);
                case (kind)
                    0, 1, 2, 3:
                    begin
                        add_byte(CH_PCT, 1'b0);
                        add_byte(dig, 1'b0);
                        add_byte(hx, fin);
                    end
                    4:
                    begin
                        add_byte(CH_PCT, 1'b0);
                        add_byte(8'($urandom_range(0, 255)), fin);
                    end
                    5:
                    begin
                        add_byte(CH_PCT, 1'b0);
                        add_byte(dig, 1'b0);
                        add_byte(8'($urandom_range(0, 255)), fin);
                    end
                    6:
                    begin
                        if ($urandom_range(0, 1) == 1)
                            add_byte(CH_PCT, fin);
                        else
                        begin
                            add_byte(CH_PCT, 1'b0);
                            add_byte(dig, fin);
                        end
                    end
                    default:
                        add_byte(8'($urandom_range(0, 255)), fin);
                endcase
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || src_valid)
            @(posedge clk);
        while (decoded_q.size() != 0)
            @(posedge clk);
        // Let any stray output show up before the verdict.
        repeat (20) @(posedge clk);

        if (!failed)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
